@@ hdl/assert_macros.svh @@
// Assertion macros used by the checker module of the HIGHT CBC core.
// Needs clk_i and rst_ni in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is applied
`define HCBC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define HCBC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ hdl/hcbc_pkg.sv @@
// Shared types, constants and byte functions of the HIGHT CBC core.
// No dependencies.
package hcbc_pkg;

  localparam int unsigned ROUND_COUNT = 32;
  localparam int unsigned BLOCK_W     = 64;
  localparam int unsigned CFG_W       = 64;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned KEY_W       = 128;
  localparam int unsigned ROW_W       = 32;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_LOW  = 2'd0,
    CFG_KEY_HIGH = 2'd1,
    CFG_IV       = 2'd2,
    CFG_MODE     = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_e;

  localparam byte_t DELTA [128] = '{
    8'h5A,8'h6D,8'h36,8'h1B,8'h0D,8'h06,8'h03,8'h41,
    8'h60,8'h30,8'h18,8'h4C,8'h66,8'h33,8'h59,8'h2C,
    8'h56,8'h2B,8'h15,8'h4A,8'h65,8'h72,8'h39,8'h1C,
    8'h4E,8'h67,8'h73,8'h79,8'h3C,8'h5E,8'h6F,8'h37,
    8'h5B,8'h2D,8'h16,8'h0B,8'h05,8'h42,8'h21,8'h50,
    8'h28,8'h54,8'h2A,8'h55,8'h6A,8'h75,8'h7A,8'h7D,
    8'h3E,8'h5F,8'h2F,8'h17,8'h4B,8'h25,8'h52,8'h29,
    8'h14,8'h0A,8'h45,8'h62,8'h31,8'h58,8'h6C,8'h76,
    8'h3B,8'h1D,8'h0E,8'h47,8'h63,8'h71,8'h78,8'h7C,
    8'h7E,8'h7F,8'h3F,8'h1F,8'h0F,8'h07,8'h43,8'h61,
    8'h70,8'h38,8'h5C,8'h6E,8'h77,8'h7B,8'h3D,8'h1E,
    8'h4F,8'h27,8'h53,8'h69,8'h34,8'h1A,8'h4D,8'h26,
    8'h13,8'h49,8'h24,8'h12,8'h09,8'h04,8'h02,8'h01,
    8'h40,8'h20,8'h10,8'h08,8'h44,8'h22,8'h11,8'h48,
    8'h64,8'h32,8'h19,8'h0C,8'h46,8'h23,8'h51,8'h68,
    8'h74,8'h3A,8'h5D,8'h2E,8'h57,8'h6B,8'h35,8'h5A
  };

  function automatic byte_t f0(byte_t a);
    return {a[6:0], a[7]} ^ {a[5:0], a[7:6]} ^ {a[0], a[7:1]};
  endfunction

  function automatic byte_t f1(byte_t a);
    return {a[4:0], a[7:5]} ^ {a[3:0], a[7:4]} ^ {a[1:0], a[7:2]};
  endfunction

  // Subkey at schedule position idx: master key byte plus delta
  function automatic byte_t key_byte(logic [KEY_W-1:0] key, logic [6:0] idx);
    logic [3:0] m;
    m = {idx[3], idx[2:0] - idx[6:4]};
    return key[{m, 3'b000} +: 8] + DELTA[idx];
  endfunction

  // Whitening on bytes 0, 2, 4, 6 with four key bytes
  function automatic logic [BLOCK_W-1:0] whiten(logic [BLOCK_W-1:0] blk,
                                                logic [31:0] w, logic sub);
    logic [BLOCK_W-1:0] r;
    r = blk;
    r[7:0]   = sub ? blk[7:0] - w[7:0]     : blk[7:0] + w[7:0];
    r[23:16] = blk[23:16] ^ w[15:8];
    r[39:32] = sub ? blk[39:32] - w[23:16] : blk[39:32] + w[23:16];
    r[55:48] = blk[55:48] ^ w[31:24];
    return r;
  endfunction

endpackage

@@ hdl/hcbc_if.sv @@
// Valid/ready channel interfaces for block input and result output.
// Depends on hcbc_pkg.
interface hcbc_in_if;
  logic                         valid;
  logic                         ready;
  logic [hcbc_pkg::BLOCK_W-1:0] data_block;
  logic                         first_block;

  modport source (output valid, data_block, first_block, input ready);
  modport sink   (input valid, data_block, first_block, output ready);
endinterface

interface hcbc_out_if;
  logic                         valid;
  logic                         ready;
  logic [hcbc_pkg::BLOCK_W-1:0] result_block;

  modport source (output valid, result_block, input ready);
  modport sink   (input valid, result_block, output ready);
endinterface

@@ hdl/hight_cbc_cipher_core.sv @@
// HIGHT-64/128 in CBC mode, one 64-bit block per beat, direction set by the
// mode register. A block is accepted only in idle: it is loaded with input
// whitening, then runs one round per cycle for 32 rounds through the shared
// round unit, the round-key row read ahead from the key memory into a
// register; the last round also whitens, chains and loads the output
// register. The input is taken while a result waits, but the last round
// holds until the output register is free. After reset and after every key
// register write the key memory is refilled in a sweep over all its rows,
// during which no block is accepted. Depends on hcbc_pkg, hcbc_if,
// hcbc_key_sched and hcbc_round.
module hight_cbc_cipher_core #(
  parameter int unsigned RoundCount = hcbc_pkg::ROUND_COUNT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [hcbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [hcbc_pkg::CFG_W-1:0]       cfg_data_i,
  hcbc_in_if.sink                          in_i,
  hcbc_out_if.source                       out_o
);

  localparam int unsigned RowW = $clog2(RoundCount);
  localparam logic [RowW-1:0] LastRow = RowW'(RoundCount - 1);

  logic [hcbc_pkg::BLOCK_W-1:0] key_low_q, key_high_q, iv_q;
  logic                         mode_q;
  logic [hcbc_pkg::BLOCK_W-1:0] chain_q, work_q, data_q, result_q;
  logic                         out_valid_q;
  hcbc_pkg::state_e             state_q, state_d;
  logic [RowW-1:0]              cnt_q, cnt_d, cnt_nx;

  logic                         key_wr, ks_busy, accept, run, last_step;
  logic                         swap, out_free, finish, rd_en;
  logic [RowW-1:0]              rd_row;
  logic [hcbc_pkg::ROW_W-1:0]   round_keys;
  logic [hcbc_pkg::BLOCK_W-1:0] round_out, final_blk, res, chain_sel, load_blk;

  // Config registers
  assign key_wr = cfg_we_i && (cfg_idx_i == hcbc_pkg::CFG_KEY_LOW ||
                               cfg_idx_i == hcbc_pkg::CFG_KEY_HIGH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_low_q  <= '0;
      key_high_q <= '0;
      iv_q       <= '0;
      mode_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hcbc_pkg::CFG_KEY_LOW:  key_low_q  <= cfg_data_i;
        hcbc_pkg::CFG_KEY_HIGH: key_high_q <= cfg_data_i;
        hcbc_pkg::CFG_IV:       iv_q       <= cfg_data_i;
        hcbc_pkg::CFG_MODE:     mode_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  hcbc_key_sched #(
    .RoundCount (RoundCount)
  ) u_key_sched (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .key_i     ({key_high_q, key_low_q}),
    .start_i   (key_wr),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (round_keys),
    .busy_o    (ks_busy)
  );

  hcbc_round u_round (
    .state_i   (work_q),
    .keys_i    (round_keys),
    .decrypt_i (mode_q),
    .swap_i    (swap),
    .state_o   (round_out)
  );

  assign run       = (state_q == hcbc_pkg::ST_RUN);
  assign last_step = (cnt_q == LastRow);
  assign cnt_nx    = cnt_q + 1'b1;
  assign swap      = mode_q ? (cnt_q != '0) : !last_step;

  assign in_i.ready = (state_q == hcbc_pkg::ST_IDLE) && !ks_busy && !key_wr;
  assign accept     = in_i.valid && in_i.ready;
  assign out_free   = !out_valid_q || out_o.ready;
  assign finish     = run && last_step && out_free;

  assign rd_en  = accept || (run && !last_step);
  assign rd_row = accept ? (mode_q ? LastRow : '0)
                         : (mode_q ? LastRow - cnt_nx : cnt_nx);

  assign chain_sel = in_i.first_block ? iv_q : chain_q;
  assign load_blk  = mode_q
      ? hcbc_pkg::whiten(in_i.data_block, key_low_q[31:0], 1'b1)
      : hcbc_pkg::whiten(in_i.data_block ^ chain_sel, key_high_q[63:32], 1'b0);
  assign final_blk = mode_q
      ? hcbc_pkg::whiten(round_out, key_high_q[63:32], 1'b1)
      : hcbc_pkg::whiten(round_out, key_low_q[31:0], 1'b0);
  assign res = mode_q ? (final_blk ^ chain_q) : final_blk;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      hcbc_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = hcbc_pkg::ST_RUN;
          cnt_d   = '0;
        end
      end
      hcbc_pkg::ST_RUN: begin
        if (!last_step) begin
          cnt_d = cnt_nx;
        end else if (out_free) begin
          state_d = hcbc_pkg::ST_IDLE;
          cnt_d   = '0;
        end
      end
      default: begin
        state_d = hcbc_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hcbc_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        chain_q <= chain_sel;
      end else if (finish) begin
        chain_q <= mode_q ? data_q : res;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_i.data_block;
      work_q <= load_blk;
    end else if (run && !last_step) begin
      work_q <= round_out;
    end
    if (finish) begin
      result_q <= res;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_block = result_q;

endmodule

@@ hdl/hcbc_key_sched.sv @@
// Round key memory: one row of four subkeys per round, refilled by a sweep
// after reset and on key change. Depends on hcbc_pkg.
module hcbc_key_sched #(
  parameter int unsigned RoundCount = hcbc_pkg::ROUND_COUNT,
  localparam int unsigned RowW = $clog2(RoundCount)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [hcbc_pkg::KEY_W-1:0]  key_i,
  input  logic                        start_i,
  input  logic                        rd_en_i,
  input  logic [RowW-1:0]             rd_row_i,
  output logic [hcbc_pkg::ROW_W-1:0]  rd_data_o,
  output logic                        busy_o
);

  localparam logic [RowW-1:0] LastRow = RowW'(RoundCount - 1);

  logic [hcbc_pkg::ROW_W-1:0] mem [RoundCount];
  logic [hcbc_pkg::ROW_W-1:0] rd_data_q;
  logic [hcbc_pkg::ROW_W-1:0] wr_data;
  logic [RowW-1:0]            cnt_q, cnt_d;
  logic                       busy_q, busy_d;

  always_comb begin
    for (int t = 0; t < 4; t++) begin
      wr_data[8*t +: 8] = hcbc_pkg::key_byte(key_i, 7'({cnt_q, 2'(t)}));
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      if (cnt_q == LastRow) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      mem[cnt_q] <= wr_data;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_row_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = busy_q;

endmodule

@@ hdl/hcbc_round.sv @@
// One HIGHT round, forward or inverse, with or without the byte rotation.
// Depends on hcbc_pkg.
module hcbc_round (
  input  logic [hcbc_pkg::BLOCK_W-1:0] state_i,
  input  logic [hcbc_pkg::ROW_W-1:0]   keys_i,
  input  logic                         decrypt_i,
  input  logic                         swap_i,
  output logic [hcbc_pkg::BLOCK_W-1:0] state_o
);

  hcbc_pkg::byte_t x [8];
  hcbc_pkg::byte_t n [8];
  hcbc_pkg::byte_t e [4];
  hcbc_pkg::byte_t a [4];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      x[k] = state_i[8*k +: 8];
    end
    // inverse rotating round takes its F inputs from the odd bytes
    for (int k = 0; k < 4; k++) begin
      e[k] = (decrypt_i && swap_i) ? x[2*k+1] : x[2*k];
    end
    a[0] = hcbc_pkg::f1(e[0]) ^ keys_i[7:0];
    a[1] = hcbc_pkg::f0(e[1]) + keys_i[15:8];
    a[2] = hcbc_pkg::f1(e[2]) ^ keys_i[23:16];
    a[3] = hcbc_pkg::f0(e[3]) + keys_i[31:24];
    n = x;
    case ({decrypt_i, swap_i})
      2'b00: begin
        n[1] = x[1] + a[0];
        n[3] = x[3] ^ a[1];
        n[5] = x[5] + a[2];
        n[7] = x[7] ^ a[3];
      end
      2'b01: begin
        n[1] = x[0];
        n[3] = x[2];
        n[5] = x[4];
        n[7] = x[6];
        n[0] = x[7] ^ a[3];
        n[2] = x[1] + a[0];
        n[4] = x[3] ^ a[1];
        n[6] = x[5] + a[2];
      end
      2'b10: begin
        n[1] = x[1] - a[0];
        n[3] = x[3] ^ a[1];
        n[5] = x[5] - a[2];
        n[7] = x[7] ^ a[3];
      end
      default: begin
        n[0] = x[1];
        n[2] = x[3];
        n[4] = x[5];
        n[6] = x[7];
        n[7] = x[0] ^ a[3];
        n[1] = x[2] - a[0];
        n[3] = x[4] ^ a[1];
        n[5] = x[6] - a[2];
      end
    endcase
    for (int k = 0; k < 8; k++) begin
      state_o[8*k +: 8] = n[k];
    end
  end

endmodule

@@ hdl/hcbc_checker.sv @@
// Port-level checks for hight_cbc_cipher_core, attached by bind.
// Depends on hcbc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hcbc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_i,
  input logic                           out_valid_i,
  input logic                           out_ready_i,
  input logic [hcbc_pkg::BLOCK_W-1:0]   result_i,
  input logic                           cfg_we_i,
  input logic [hcbc_pkg::CFG_IDX_W-1:0] cfg_idx_i
);

  logic in_beat, out_stall, key_wr;

  assign in_beat   = in_valid_i && in_ready_i;
  assign out_stall = out_valid_i && !out_ready_i;
  assign key_wr    = cfg_we_i && (cfg_idx_i == hcbc_pkg::CFG_KEY_LOW ||
                                  cfg_idx_i == hcbc_pkg::CFG_KEY_HIGH);

  `HCBC_ASSERT(a_out_hold, out_stall |=> out_valid_i && $stable(result_i), "result beat not held")
  `HCBC_ASSERT(a_busy_after_accept, in_beat |=> !in_ready_i, "block taken mid-rounds")
  `HCBC_ASSERT(a_key_refill, key_wr |=> !in_ready_i, "block taken during key refill")
  `HCBC_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |=> !out_valid_i && !in_ready_i, "ports active after reset")

endmodule

bind hight_cbc_cipher_core hcbc_checker u_hcbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .result_i    (out_o.result_block),
  .cfg_we_i    (cfg_we_i),
  .cfg_idx_i   (cfg_idx_i)
);
